@@ rtl/core/tras_pkg.sv @@
// Shared types and constants for the temporary register allocator with spill stack.
// Holds request/response payload structs, operation and result codes, and FSM states.
// No dependencies; imported by the top level module in rtl/core.
package tras_pkg;

   // Default sizing, handed to the top level parameters
   localparam int SPILL_DEPTH_DEF = 32;
   localparam int MARK_DEPTH_DEF  = 32;
   localparam int INDEX_MAX_DEF   = 63;

   // Register count after reset and its clamp limits
   localparam logic [3:0] NUM_REGS_RESET = 4'd3;
   localparam logic [3:0] NUM_REGS_MIN   = 4'd1;
   localparam logic [3:0] NUM_REGS_MAX   = 4'd8;

   // Request modes
   localparam logic [2:0] MODE_INIT    = 3'd0;
   localparam logic [2:0] MODE_ALLOC   = 3'd1;
   localparam logic [2:0] MODE_FREE    = 3'd2;
   localparam logic [2:0] MODE_MARK    = 3'd3;
   localparam logic [2:0] MODE_RELEASE = 3'd4;

   // Result kinds
   localparam logic [1:0] KIND_ACK     = 2'd0;
   localparam logic [1:0] KIND_SPILL   = 2'd1;
   localparam logic [1:0] KIND_RESTORE = 2'd2;

   // Error codes
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_OVERFLOW = 2'd1;
   localparam logic [1:0] ERR_SATURATE = 2'd2;

   // Register counts carried by a free request
   localparam logic [1:0] COUNT_ONE = 2'd1;
   localparam logic [1:0] COUNT_TWO = 2'd2;

   typedef struct packed {
      logic [2:0] mode;
      logic [2:0] first_reg;
      logic [2:0] second_reg;
      logic [1:0] reg_count;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [2:0] reg_res;
      logic [1:0] error;
      logic       last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MODDIV,
      ST_ALLOC,
      ST_GRANT,
      ST_REL_WAIT,
      ST_POP
   } state_type;

endpackage

@@ rtl/core/temp_register_allocator_spill_top.sv @@
// Top level of the temporary register allocator with spill stack.
// Depends on tras_pkg and tras_ram (spill stack and mark stack memories).
//
// Usage:
//  - Requests: drive req_data and raise start; the request transfers at a clock
//    edge where start is high and busy is low.
//  - Results: each result shows on rsp_data for one cycle with rsp_strobe high.
//    Every request ends with one result of kind ack with last set. The receiver
//    cannot stall the block; results are never held back.
//  - Configuration: csr_data transfers when csr_valid and csr_ready are high;
//    csr_ready is high while the block is idle.
// Sequencing by mode:
//  - Init, free, mark, unused modes and a release with no mark: the result is
//    registered, shown in the next cycle; a new request can transfer every cycle.
//  - Allocate: the allocate state issues the grant; a needed spill push takes that
//    slot and the grant state then sends the grant. After a register count write,
//    the first allocate (unless an init comes first) rebuilds next_index mod count
//    with a bit-serial remainder unit, one remainder step per index bit.
//  - Release: the mark memory is read at the transfer and latched in a wait
//    state, then one restore per cycle from the spill memory, ack after the last.
// Reset: synchronous; clears all stacks to empty, next index to zero and the
// register count to three. No memory clearing pass is needed.
module temp_register_allocator_spill_top #(
   parameter int SPILL_DEPTH = tras_pkg::SPILL_DEPTH_DEF,
   parameter int MARK_DEPTH  = tras_pkg::MARK_DEPTH_DEF,
   parameter int INDEX_MAX   = tras_pkg::INDEX_MAX_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  tras_pkg::req_type req_data,
   output logic              rsp_strobe,
   output tras_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [3:0]        csr_data
);
   import tras_pkg::*;

   localparam int IDX_W = $clog2(INDEX_MAX + 1);
   localparam int SD_W  = $clog2(SPILL_DEPTH + 1);
   localparam int MD_W  = $clog2(MARK_DEPTH + 1);
   localparam int SA_W  = $clog2(SPILL_DEPTH);
   localparam int MA_W  = $clog2(MARK_DEPTH);
   localparam int CNT_W = $clog2(IDX_W);

   // Modular step helpers on the round-robin register pointer
   function automatic logic [2:0] mod_inc(input logic [2:0] m, input logic [2:0] top);
      mod_inc = (m == top) ? 3'd0 : m + 3'd1;
   endfunction

   function automatic logic [2:0] mod_dec(input logic [2:0] m, input logic [2:0] top);
      mod_dec = (m == 3'd0) ? top : m - 3'd1;
   endfunction

   // State registers
   state_type        state_ff, state_in;
   logic [3:0]       nreg_ff, nreg_in;
   logic [IDX_W-1:0] ni_ff, ni_in;
   logic [IDX_W-1:0] hw_ff, hw_in;
   logic [SD_W-1:0]  sd_ff, sd_in;
   logic [MD_W-1:0]  md_ff, md_in;
   logic [2:0]       mod_ff, mod_in;
   logic             mod_ok_ff, mod_ok_in;
   logic [2:0]       rem_ff, rem_in;
   logic [IDX_W-1:0] sh_ff, sh_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [SD_W-1:0]  tgt_ff, tgt_in;
   logic             pend_ff, pend_in;
   logic             rsp_strobe_ff, rsp_strobe_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   // Memory ports
   logic            sp_wr_en, sp_rd_en;
   logic [SA_W-1:0] sp_wr_addr, sp_rd_addr;
   logic [2:0]      sp_rd_data;
   logic            mk_wr_en, mk_rd_en;
   logic [MA_W-1:0] mk_wr_addr, mk_rd_addr;
   logic [SD_W-1:0] mk_rd_data;

   // Shared decode
   logic             accept;
   logic [3:0]       eff;
   logic [2:0]       eff_m1;
   logic             spill_full;
   logic             mark_full;
   logic             need_spill;
   logic             idx_sat;
   logic [IDX_W-1:0] ni_inc;
   logic [2:0]       mod_next;
   logic [3:0]       rem_sh;
   logic [2:0]       rem_nx;
   logic             pop_go;
   logic [SD_W-1:0]  sd_m1;
   logic [MD_W-1:0]  md_m1;
   logic             do1, do2;
   logic [IDX_W-1:0] ni1, ni2;
   logic [2:0]       mod1, mod2;

   assign accept     = start & ~busy;
   assign busy       = (state_ff != ST_IDLE);
   assign csr_ready  = (state_ff == ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // Clamp the register count to 1..8
   always_comb begin
      if (nreg_ff < NUM_REGS_MIN) begin
         eff = NUM_REGS_MIN;
      end else if (nreg_ff > NUM_REGS_MAX) begin
         eff = NUM_REGS_MAX;
      end else begin
         eff = nreg_ff;
      end
   end
   assign eff_m1 = 3'(eff - 4'd1);

   // Allocate decode
   assign spill_full = (sd_ff >= SD_W'(SPILL_DEPTH));
   assign mark_full  = (md_ff >= MD_W'(MARK_DEPTH));
   assign need_spill = (ni_ff > hw_ff);
   assign idx_sat    = (ni_ff >= IDX_W'(INDEX_MAX));
   assign ni_inc     = idx_sat ? IDX_W'(INDEX_MAX) : ni_ff + IDX_W'(1);
   assign mod_next   = idx_sat ? mod_ff : mod_inc(mod_ff, eff_m1);

   // Bit-serial remainder step
   assign rem_sh = {rem_ff, sh_ff[IDX_W-1]};
   assign rem_nx = (rem_sh >= eff) ? 3'(rem_sh - eff) : rem_sh[2:0];

   // Release decode
   assign sd_m1  = sd_ff - SD_W'(1);
   assign md_m1  = md_ff - MD_W'(1);
   assign pop_go = (sd_ff > tgt_ff) && (sd_ff != '0);

   // Free: up to two decrements, the second sees the first
   assign do1  = ((req_data.reg_count == COUNT_ONE) || (req_data.reg_count == COUNT_TWO))
                 && ({1'b0, req_data.first_reg} < eff) && (ni_ff != '0);
   assign ni1  = do1 ? ni_ff - IDX_W'(1) : ni_ff;
   assign mod1 = do1 ? mod_dec(mod_ff, eff_m1) : mod_ff;
   assign do2  = (req_data.reg_count == COUNT_TWO)
                 && ({1'b0, req_data.second_reg} < eff) && (ni1 != '0);
   assign ni2  = do2 ? ni1 - IDX_W'(1) : ni1;
   assign mod2 = do2 ? mod_dec(mod1, eff_m1) : mod1;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.mode == MODE_ALLOC) begin
               state_in = mod_ok_ff ? ST_ALLOC : ST_MODDIV;
            end else if (accept && req_data.mode == MODE_RELEASE && md_ff != '0) begin
               state_in = ST_REL_WAIT;
            end
         end
         ST_MODDIV: begin
            if (cnt_ff == '0) begin
               state_in = ST_ALLOC;
            end
         end
         ST_ALLOC: begin
            state_in = need_spill ? ST_GRANT : ST_IDLE;
         end
         ST_GRANT: begin
            state_in = ST_IDLE;
         end
         ST_REL_WAIT: begin
            state_in = ST_POP;
         end
         ST_POP: begin
            if (!pop_go && !pend_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath, memory control and result
   always_comb begin
      nreg_in       = nreg_ff;
      ni_in         = ni_ff;
      hw_in         = hw_ff;
      sd_in         = sd_ff;
      md_in         = md_ff;
      mod_in        = mod_ff;
      mod_ok_in     = mod_ok_ff;
      rem_in        = rem_ff;
      sh_in         = sh_ff;
      cnt_in        = cnt_ff;
      tgt_in        = tgt_ff;
      pend_in       = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      sp_wr_en      = 1'b0;
      sp_wr_addr    = sd_ff[SA_W-1:0];
      sp_rd_en      = 1'b0;
      sp_rd_addr    = sd_m1[SA_W-1:0];
      mk_wr_en      = 1'b0;
      mk_wr_addr    = md_ff[MA_W-1:0];
      mk_rd_en      = 1'b0;
      mk_rd_addr    = md_m1[MA_W-1:0];

      // Register count write invalidates the pointer
      if (csr_valid && csr_ready) begin
         nreg_in   = csr_data;
         mod_ok_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_data_in = '{kind: KIND_ACK, reg_res: 3'd0, error: ERR_NONE, last: 1'b1};
               case (req_data.mode)
                  MODE_INIT: begin
                     ni_in         = '0;
                     hw_in         = IDX_W'(eff_m1);
                     sd_in         = '0;
                     md_in         = '0;
                     mod_in        = 3'd0;
                     mod_ok_in     = 1'b1;
                     rsp_strobe_in = 1'b1;
                  end
                  MODE_ALLOC: begin
                     rem_in = 3'd0;
                     sh_in  = ni_ff;
                     cnt_in = CNT_W'(IDX_W - 1);
                  end
                  MODE_FREE: begin
                     ni_in         = ni2;
                     mod_in        = mod2;
                     rsp_strobe_in = 1'b1;
                  end
                  MODE_MARK: begin
                     if (mark_full) begin
                        rsp_data_in.error = ERR_OVERFLOW;
                     end else begin
                        mk_wr_en = 1'b1;
                        md_in    = md_ff + MD_W'(1);
                     end
                     rsp_strobe_in = 1'b1;
                  end
                  MODE_RELEASE: begin
                     if (md_ff != '0) begin
                        mk_rd_en = 1'b1;
                        md_in    = md_m1;
                     end else begin
                        rsp_strobe_in = 1'b1;
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         ST_MODDIV: begin
            rem_in = rem_nx;
            sh_in  = sh_ff << 1;
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               mod_in    = rem_nx;
               mod_ok_in = 1'b1;
            end
         end
         ST_ALLOC: begin
            rsp_strobe_in = 1'b1;
            if (need_spill) begin
               // Old temporary in this register goes to the spill stack
               rsp_data_in = '{kind: KIND_SPILL, reg_res: mod_ff,
                               error: spill_full ? ERR_OVERFLOW : ERR_NONE, last: 1'b0};
               if (!spill_full) begin
                  sp_wr_en = 1'b1;
                  sd_in    = sd_ff + SD_W'(1);
               end
               hw_in = ni_ff;
            end else begin
               rsp_data_in = '{kind: KIND_ACK, reg_res: mod_ff,
                               error: idx_sat ? ERR_SATURATE : ERR_NONE, last: 1'b1};
               ni_in  = ni_inc;
               mod_in = mod_next;
            end
         end
         ST_GRANT: begin
            rsp_strobe_in = 1'b1;
            rsp_data_in   = '{kind: KIND_ACK, reg_res: mod_ff,
                              error: idx_sat ? ERR_SATURATE : ERR_NONE, last: 1'b1};
            ni_in  = ni_inc;
            mod_in = mod_next;
         end
         ST_REL_WAIT: begin
            tgt_in = mk_rd_data;
         end
         ST_POP: begin
            // Restore read last cycle goes out now
            if (pend_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_data_in   = '{kind: KIND_RESTORE, reg_res: sp_rd_data,
                                 error: ERR_NONE, last: 1'b0};
            end
            if (pop_go) begin
               sp_rd_en = 1'b1;
               sd_in    = sd_m1;
               pend_in  = 1'b1;
            end else if (!pend_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_data_in   = '{kind: KIND_ACK, reg_res: 3'd0, error: ERR_NONE, last: 1'b1};
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         nreg_ff       <= NUM_REGS_RESET;
         ni_ff         <= '0;
         hw_ff         <= IDX_W'(NUM_REGS_RESET - 4'd1);
         sd_ff         <= '0;
         md_ff         <= '0;
         mod_ff        <= 3'd0;
         mod_ok_ff     <= 1'b1;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         nreg_ff       <= nreg_in;
         ni_ff         <= ni_in;
         hw_ff         <= hw_in;
         sd_ff         <= sd_in;
         md_ff         <= md_in;
         mod_ff        <= mod_in;
         mod_ok_ff     <= mod_ok_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Working and payload registers
   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      sh_ff       <= sh_in;
      cnt_ff      <= cnt_in;
      tgt_ff      <= tgt_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Spill stack: registers pushed out by allocation
   tras_ram #(
      .WIDTH (3),
      .DEPTH (SPILL_DEPTH)
   ) u_spill_ram (
      .clock   (clock),
      .wr_en   (sp_wr_en),
      .wr_addr (sp_wr_addr),
      .wr_data (mod_ff),
      .rd_en   (sp_rd_en),
      .rd_addr (sp_rd_addr),
      .rd_data (sp_rd_data)
   );

   // Mark stack: saved spill depths
   tras_ram #(
      .WIDTH (SD_W),
      .DEPTH (MARK_DEPTH)
   ) u_mark_ram (
      .clock   (clock),
      .wr_en   (mk_wr_en),
      .wr_addr (mk_wr_addr),
      .wr_data (sd_ff),
      .rd_en   (mk_rd_en),
      .rd_addr (mk_rd_addr),
      .rd_data (mk_rd_data)
   );

endmodule

@@ rtl/core/tras_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing; used for the spill stack and the mark stack.
module tras_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port, holds its value when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ verif/tb_temp_register_allocator_spill_top.sv @@
// Testbench for temp_register_allocator_spill_top: directed and random request streams,
// every result compared against an in-bench model of the allocator and its stacks.
// Depends on tras_pkg and the RTL under rtl/core.
module tb_temp_register_allocator_spill_top;
   timeunit 1ns;
   timeprecision 1ps;
   import tras_pkg::*;

   localparam int SPILL_SLOTS   = SPILL_DEPTH_DEF;
   localparam int MARK_SLOTS    = MARK_DEPTH_DEF;
   localparam int TOP_INDEX     = INDEX_MAX_DEF;
   localparam int SETTLE_CYCLES = 40;

   // Free counts the package leaves unnamed
   localparam logic [1:0] COUNT_NONE  = 2'd0;
   localparam logic [1:0] COUNT_THREE = 2'd3;

   logic       clock = 1'b0;
   logic       reset;
   logic       start;
   logic       busy;
   req_type    req_data;
   logic       rsp_strobe;
   rsp_type    rsp_data;
   logic       csr_valid;
   logic       csr_ready;
   logic [3:0] csr_data;

   temp_register_allocator_spill_top dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // Allocator model state
   logic [3:0] regs_cfg;
   logic [5:0] next_idx;
   logic [5:0] high_water;
   logic [5:0] spill_top;
   logic [5:0] mark_top;
   logic [2:0] spill_mem [SPILL_SLOTS];
   logic [5:0] mark_mem [MARK_SLOTS];

   rsp_type rsp_due [$];
   int      errors = 0;
   int      idle_pct = 0;
   int      items_sent = 0;

   // Register count as the block uses it: 0 acts as 1, above 8 as 8
   function automatic int active_regs();
      if (regs_cfg < NUM_REGS_MIN) return int'(NUM_REGS_MIN);
      if (regs_cfg > NUM_REGS_MAX) return int'(NUM_REGS_MAX);
      return int'(regs_cfg);
   endfunction

   function automatic void clear_model();
      next_idx   = '0;
      high_water = 6'(active_regs() - 1);
      spill_top  = '0;
      mark_top   = '0;
   endfunction

   function automatic void push_rsp(logic [1:0] kind, logic [2:0] r, logic [1:0] err,
                                    logic last);
      rsp_type res;
      res.kind    = kind;
      res.reg_res = r;
      res.error   = err;
      res.last    = last;
      rsp_due.push_back(res);
   endfunction

   function automatic void free_reg(logic [2:0] r);
      if (r < active_regs() && next_idx > 0) next_idx--;
   endfunction

   // Update the model for one accepted request and queue the results it causes
   function automatic void allocator_step(req_type r);
      logic [2:0] slot;
      logic [1:0] err;
      slot = '0;
      err  = ERR_NONE;
      case (r.mode)
         MODE_INIT: clear_model();
         MODE_ALLOC: begin
            slot = 3'(next_idx % active_regs());
            // register still holds an older temporary: push it first
            if (next_idx > high_water) begin
               if (spill_top < SPILL_SLOTS) begin
                  spill_mem[5'(spill_top)] = slot;
                  spill_top++;
                  push_rsp(KIND_SPILL, slot, ERR_NONE, 1'b0);
               end else begin
                  push_rsp(KIND_SPILL, slot, ERR_OVERFLOW, 1'b0);
               end
               high_water = next_idx;
            end
            if (next_idx >= TOP_INDEX) begin
               next_idx = 6'(TOP_INDEX);
               err      = ERR_SATURATE;
            end else begin
               next_idx++;
            end
         end
         MODE_FREE: begin
            if (r.reg_count == COUNT_ONE || r.reg_count == COUNT_TWO) free_reg(r.first_reg);
            if (r.reg_count == COUNT_TWO) free_reg(r.second_reg);
         end
         MODE_MARK: begin
            if (mark_top < MARK_SLOTS) begin
               mark_mem[5'(mark_top)] = spill_top;
               mark_top++;
            end else begin
               err = ERR_OVERFLOW;
            end
         end
         MODE_RELEASE: begin
            if (mark_top > 0) begin
               mark_top--;
               while (spill_top > mark_mem[5'(mark_top)]) begin
                  spill_top--;
                  push_rsp(KIND_RESTORE, spill_mem[5'(spill_top)], ERR_NONE, 1'b0);
               end
            end
         end
         default: ;
      endcase
      push_rsp(KIND_ACK, slot, err, 1'b1);
   endfunction

   function automatic req_type make_req(logic [2:0] mode, logic [2:0] a, logic [2:0] b,
                                        logic [1:0] n);
      req_type r;
      r.mode       = mode;
      r.first_reg  = a;
      r.second_reg = b;
      r.reg_count  = n;
      return r;
   endfunction

   function automatic req_type rand_req(logic [2:0] mode);
      return make_req(mode, 3'($urandom_range(7)), 3'($urandom_range(7)),
                      2'($urandom_range(3)));
   endfunction

   // One request transfer, with random idle cycles ahead of it
   task automatic send_req(input req_type r);
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      allocator_step(r);
      items_sent++;
   endtask

   // Stop sending and wait until every queued result has come back
   task automatic drain(input int extra);
      @(negedge clock);
      start <= 1'b0;
      while (rsp_due.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_regs_cfg(input logic [3:0] v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      regs_cfg = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Result checker: compare each strobed result with the oldest queued one
   task automatic check_field(input string name, input logic [2:0] want, input logic [2:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (rsp_due.size() == 0) begin
            $error("unexpected result: kind %0d reg %0d error %0d last %0d",
                   rsp_data.kind, rsp_data.reg_res, rsp_data.error, rsp_data.last);
            errors++;
         end else begin
            want = rsp_due.pop_front();
            check_field("kind", 3'(want.kind), 3'(rsp_data.kind));
            check_field("reg_res", want.reg_res, rsp_data.reg_res);
            check_field("error", 3'(want.error), 3'(rsp_data.error));
            check_field("last", 3'(want.last), 3'(rsp_data.last));
         end
      end
   end

   // Every mode at the reset register count, free corner cases, unused modes
   task automatic test_modes();
      send_req(make_req(MODE_INIT, '1, '1, '1));
      // fourth allocate wraps onto register 0 and spills it
      repeat (4) send_req(make_req(MODE_ALLOC, '0, '0, COUNT_NONE));
      send_req(make_req(MODE_MARK, '0, '0, COUNT_NONE));
      send_req(make_req(MODE_ALLOC, '1, '1, '1));
      send_req(make_req(MODE_FREE, 3'd0, 3'd7, COUNT_TWO));
      send_req(make_req(MODE_FREE, 3'd7, 3'd0, COUNT_ONE));
      send_req(make_req(MODE_FREE, 3'd0, 3'd0, COUNT_NONE));
      send_req(make_req(MODE_FREE, 3'd0, 3'd1, COUNT_THREE));
      send_req(make_req(MODE_RELEASE, '0, '0, COUNT_NONE));
      // no mark left: plain ack
      send_req(make_req(MODE_RELEASE, '1, '1, '1));
      for (int m = MODE_RELEASE + 1; m < 8; m++) send_req(make_req(3'(m), '1, '1, '1));
      // free down to index zero, then a free that must be ignored
      send_req(make_req(MODE_FREE, 3'd1, 3'd2, COUNT_TWO));
      send_req(make_req(MODE_FREE, 3'd1, 3'd2, COUNT_TWO));
      send_req(make_req(MODE_FREE, 3'd0, 3'd0, COUNT_ONE));
   endtask

   // Register count written out of range on both sides
   task automatic test_reg_count_clamp();
      drain(4);
      write_regs_cfg(4'd0);
      send_req(make_req(MODE_INIT, '0, '0, COUNT_NONE));
      repeat (3) send_req(rand_req(MODE_ALLOC));
      drain(4);
      write_regs_cfg(4'd15);
      send_req(make_req(MODE_INIT, '0, '0, COUNT_NONE));
      repeat (2) send_req(rand_req(MODE_ALLOC));
      send_req(make_req(MODE_FREE, 3'd7, 3'd0, COUNT_ONE));
   endtask

   // More marks than the mark stack holds
   task automatic test_mark_overflow();
      send_req(rand_req(MODE_INIT));
      for (int i = 0; i < MARK_SLOTS + 2; i++) begin
         send_req(rand_req(MODE_MARK));
         if (i % 8 == 7) send_req(rand_req(MODE_ALLOC));
      end
      repeat (2) send_req(rand_req(MODE_RELEASE));
   endtask

   // Allocate past the spill stack and the index limit, then unwind it all
   task automatic test_spill_overflow();
      drain(4);
      write_regs_cfg(4'd8);
      send_req(rand_req(MODE_INIT));
      send_req(rand_req(MODE_MARK));
      repeat (TOP_INDEX + 3) send_req(rand_req(MODE_ALLOC));
      send_req(rand_req(MODE_RELEASE));
   endtask

   // Random traffic: allocate bursts, mark/allocate/release scopes, frees, noise
   task automatic test_random_mix(input logic [3:0] regs, input int quota);
      int stop_at;
      int pick;
      int burst;
      drain(4);
      write_regs_cfg(regs);
      send_req(rand_req(MODE_INIT));
      stop_at = items_sent + quota;
      while (items_sent < stop_at) begin
         pick  = $urandom_range(99);
         burst = $urandom_range(1, 6);
         if (pick < 35) begin
            repeat (burst) send_req(rand_req(MODE_ALLOC));
         end else if (pick < 60) begin
            send_req(rand_req(MODE_MARK));
            repeat (burst) send_req(rand_req(MODE_ALLOC));
            if ($urandom_range(1)) send_req(rand_req(MODE_FREE));
            send_req(rand_req(MODE_RELEASE));
         end else if (pick < 80) begin
            send_req(rand_req(MODE_FREE));
         end else begin
            send_req(rand_req(3'($urandom_range(7))));
         end
      end
   endtask

   initial begin
      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_data  = '0;
      regs_cfg  = NUM_REGS_RESET;
      clear_model();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      idle_pct = 28;
      test_modes();
      test_reg_count_clamp();
      test_random_mix(4'd5, 25);

      idle_pct = 51;
      test_random_mix(4'd1, 10);
      test_mark_overflow();

      idle_pct = 0;
      test_spill_overflow();
      test_random_mix(4'd2, 10);

      drain(SETTLE_CYCLES);
      if (errors == 0 && rsp_due.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Run limit
   initial begin
      #5ms;
      $display("Verification failed");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/tras_pkg.sv
rtl/core/tras_ram.sv
rtl/core/temp_register_allocator_spill_top.sv
verif/tb_temp_register_allocator_spill_top.sv
